// ===== sv/atd_pkg.sv =====
`timescale 1ns / 1ps
// atd_pkg: shared constants for the audio token decoder
// marker codes, decode phases, generator kinds, lfsr seed; no dependencies

package atd_pkg;

   localparam int HISTORY_DEPTH_DEF = 1024;
   localparam int SPR_DEF           = 16;
   localparam int COUNT_W           = 5;
   localparam int LEN_W             = 10;

   // marker bytes
   localparam logic [7:0] MK_RUN        = 8'd64;
   localparam logic [7:0] MK_REP4       = 8'd135;
   localparam logic [7:0] MK_REP3       = 8'd192;
   localparam logic [7:0] MK_NOISE      = 8'd2;
   localparam logic [7:0] MK_COPY_SHORT = 8'd254;
   localparam logic [7:0] MK_COPY_LONG  = 8'd100;

   // decode phases
   localparam logic [1:0] PH_MARKER = 2'd0;
   localparam logic [1:0] PH_ARG    = 2'd1;
   localparam logic [1:0] PH_COUNT  = 2'd2;

   // pending marker codes
   localparam logic [2:0] PM_RUN        = 3'd0;
   localparam logic [2:0] PM_REP4       = 3'd1;
   localparam logic [2:0] PM_REP3       = 3'd2;
   localparam logic [2:0] PM_NOISE      = 3'd3;
   localparam logic [2:0] PM_COPY_SHORT = 3'd4;
   localparam logic [2:0] PM_COPY_LONG  = 3'd5;

   // sample generator kinds
   localparam logic [1:0] GK_CONST = 2'd0;
   localparam logic [1:0] GK_NOISE = 2'd1;
   localparam logic [1:0] GK_COPY  = 2'd2;

   localparam logic [LEN_W-1:0] COPY_SHORT_BIAS = 10'd20;
   localparam logic [LEN_W-1:0] COPY_LONG_BIAS  = 10'd276;
   localparam logic [7:0]       NOISE_BASE      = 8'd127;
   localparam logic [7:0]       BEFORE_START    = 8'd128;
   localparam logic [15:0]      LFSR_SEED       = 16'hACE1;

endpackage

// ===== sv/audio_token_decoder.sv =====
`timescale 1ns / 1ps
// audio_token_decoder: byte stream token decoder with history ring and sample packing
// depends on atd_pkg
//
// channel | dir | ports                                   | transaction
// req     | in  | req_valid, req_ready, req_in_byte       | one compressed byte
// rsp     | out | rsp_valid, rsp_ready, rsp_samples_low,  | one group of up to
//         |     | rsp_samples_high, rsp_sample_count,     | SAMPLES_PER_RESULT samples
//         |     | rsp_last_group                          |
//
// a byte that makes n samples keeps req_ready low until all n samples are written back,
// one sample per cycle through the history memory read/write path unless the result
// register stalls generation (a long copy makes up to 531 samples)
// history read is registered; copies start only after all earlier writes are done
// reset is synchronous; history is not cleared, copies before stream start read 128
// a full group waits in the result register; generation stalls only when that register
// is still occupied and the next group completes

module audio_token_decoder import atd_pkg::*; #(
   parameter int HISTORY_DEPTH      = HISTORY_DEPTH_DEF,
   parameter int SAMPLES_PER_RESULT = SPR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_samples_low,
   output logic [63:0]        rsp_samples_high,
   output logic [COUNT_W-1:0] rsp_sample_count,
   output logic               rsp_last_group
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int GI = $clog2(SAMPLES_PER_RESULT);
   localparam logic [AW:0]   FILL_FULL = (AW+1)'(HISTORY_DEPTH);
   localparam logic [GI-1:0] GRP_LAST  = GI'(SAMPLES_PER_RESULT - 1);

   // decoder state
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       pmark_ff, pmark_in;
   logic [7:0]       runv_ff, runv_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW:0]      fill_ff, fill_in;
   logic [15:0]      lfsr_ff, lfsr_in;

   // sample generator
   logic             busy_ff, busy_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       val_ff, val_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] dist_ff, dist_in;
   logic [AW-1:0]    rd_ff, rd_in;

   // write-back stage
   logic             s1_v_ff, s1_v_in;
   logic             s1_mem_ff, s1_mem_in;
   logic [7:0]       s1_val_ff, s1_val_in;
   logic             s1_last_ff, s1_last_in;

   // group packing and result register
   logic [SAMPLES_PER_RESULT-1:0][7:0] grp_ff, grp_in;
   logic [GI-1:0]    gcnt_ff, gcnt_in;
   logic [15:0][7:0] out_ff, out_in;
   logic [COUNT_W-1:0] ocnt_ff, ocnt_in;
   logic             olast_ff, olast_in;
   logic             ov_ff, ov_in;

   // history memory
   logic [7:0]       hist_mem [HISTORY_DEPTH];
   logic [7:0]       hist_q;
   logic             rd_en;

   logic             req_fire, issue, adv, retire, complete, fb;
   logic [7:0]       smp;
   logic [LEN_W-1:0] d_new;

   assign req_ready = !busy_ff && !s1_v_ff;
   assign req_fire  = req_valid && req_ready;
   assign smp       = s1_mem_ff ? hist_q : s1_val_ff;
   assign complete  = s1_last_ff || (gcnt_ff == GRP_LAST);
   assign retire    = s1_v_ff && (!complete || !ov_ff || rsp_ready);
   assign adv       = !s1_v_ff || retire;
   assign issue     = busy_ff && adv;
   assign rd_en     = issue && (kind_ff == GK_COPY);
   assign fb        = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
   assign d_new     = (pmark_ff == PM_COPY_LONG) ? (LEN_W'(req_in_byte) + COPY_LONG_BIAS)
                                                 : (LEN_W'(req_in_byte) + COPY_SHORT_BIAS);

   // generator and decode
   always_comb begin
      phase_in   = phase_ff;
      pmark_in   = pmark_ff;
      runv_in    = runv_ff;
      fill_in    = fill_ff;
      lfsr_in    = lfsr_ff;
      busy_in    = busy_ff;
      kind_in    = kind_ff;
      val_in     = val_ff;
      rem_in     = rem_ff;
      dist_in    = dist_ff;
      rd_in      = rd_ff;
      s1_v_in    = s1_v_ff && !retire;
      s1_mem_in  = s1_mem_ff;
      s1_val_in  = s1_val_ff;
      s1_last_in = s1_last_ff;

      if (issue) begin
         s1_v_in    = 1'b1;
         s1_mem_in  = 1'b0;
         s1_last_in = (rem_ff == LEN_W'(1));
         rem_in     = rem_ff - LEN_W'(1);
         busy_in    = (rem_ff != LEN_W'(1));
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + (AW+1)'(1);
         end
         case (kind_ff)
            GK_NOISE: begin
               s1_val_in = NOISE_BASE + 8'(lfsr_ff[0]);
               lfsr_in   = {fb, lfsr_ff[15:1]};
            end
            GK_COPY: begin
               rd_in = rd_ff + AW'(1);
               if (fill_ff < (AW+1)'(dist_ff)) begin
                  s1_val_in = BEFORE_START;
               end else begin
                  s1_mem_in = 1'b1;
               end
            end
            default: begin
               s1_val_in = val_ff;
            end
         endcase
      end

      if (req_fire) begin
         case (phase_ff)
            PH_MARKER: begin
               phase_in = PH_ARG;
               case (req_in_byte)
                  MK_RUN:        pmark_in = PM_RUN;
                  MK_REP4:       pmark_in = PM_REP4;
                  MK_REP3:       pmark_in = PM_REP3;
                  MK_NOISE:      pmark_in = PM_NOISE;
                  MK_COPY_SHORT: pmark_in = PM_COPY_SHORT;
                  MK_COPY_LONG:  pmark_in = PM_COPY_LONG;
                  default: begin
                     // literal sample
                     phase_in = PH_MARKER;
                     busy_in  = 1'b1;
                     kind_in  = GK_CONST;
                     val_in   = req_in_byte;
                     rem_in   = LEN_W'(1);
                  end
               endcase
            end
            PH_ARG: begin
               phase_in = PH_MARKER;
               case (pmark_ff)
                  PM_RUN: begin
                     runv_in  = req_in_byte;
                     phase_in = PH_COUNT;
                  end
                  PM_REP4, PM_REP3: begin
                     busy_in = 1'b1;
                     kind_in = GK_CONST;
                     val_in  = req_in_byte;
                     rem_in  = (pmark_ff == PM_REP4) ? LEN_W'(4) : LEN_W'(3);
                  end
                  PM_NOISE: begin
                     busy_in = (req_in_byte != 8'd0);
                     kind_in = GK_NOISE;
                     rem_in  = LEN_W'(req_in_byte);
                  end
                  PM_COPY_SHORT, PM_COPY_LONG: begin
                     busy_in = 1'b1;
                     kind_in = GK_COPY;
                     rem_in  = d_new;
                     dist_in = d_new;
                     rd_in   = wp_ff - AW'(d_new);
                  end
                  default: begin
                     busy_in = 1'b0;
                  end
               endcase
            end
            default: begin
               phase_in = PH_MARKER;
               busy_in  = (req_in_byte != 8'd0);
               kind_in  = GK_CONST;
               val_in   = runv_ff;
               rem_in   = LEN_W'(req_in_byte);
            end
         endcase
      end
   end

   // write-back, packing, result register
   always_comb begin
      wp_in    = wp_ff;
      grp_in   = grp_ff;
      gcnt_in  = gcnt_ff;
      out_in   = out_ff;
      ocnt_in  = ocnt_ff;
      olast_in = olast_ff;
      ov_in    = ov_ff && !rsp_ready;
      if (retire) begin
         wp_in = wp_ff + AW'(1);
         if (complete) begin
            for (int l = 0; l < 16; l++) begin
               if (l < SAMPLES_PER_RESULT && GI'(l) == gcnt_ff) begin
                  out_in[l] = smp;
               end else if (l < SAMPLES_PER_RESULT) begin
                  out_in[l] = grp_ff[l];
               end else begin
                  out_in[l] = 8'd0;
               end
            end
            ocnt_in  = COUNT_W'(gcnt_ff) + COUNT_W'(1);
            olast_in = s1_last_ff;
            ov_in    = 1'b1;
            grp_in   = '0;
            gcnt_in  = '0;
         end else begin
            grp_in[gcnt_ff] = smp;
            gcnt_in         = gcnt_ff + GI'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MARKER;
         pmark_ff <= PM_RUN;
         runv_ff  <= 8'd0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         lfsr_ff  <= LFSR_SEED;
         busy_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         gcnt_ff  <= '0;
         grp_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pmark_ff <= pmark_in;
         runv_ff  <= runv_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         lfsr_ff  <= lfsr_in;
         busy_ff  <= busy_in;
         s1_v_ff  <= s1_v_in;
         gcnt_ff  <= gcnt_in;
         grp_ff   <= grp_in;
         ov_ff    <= ov_in;
      end
      kind_ff    <= kind_in;
      val_ff     <= val_in;
      rem_ff     <= rem_in;
      dist_ff    <= dist_in;
      rd_ff      <= rd_in;
      s1_mem_ff  <= s1_mem_in;
      s1_val_ff  <= s1_val_in;
      s1_last_ff <= s1_last_in;
      out_ff     <= out_in;
      ocnt_ff    <= ocnt_in;
      olast_ff   <= olast_in;
   end

   // history ring: write on retire, registered read held while stalled
   always_ff @(posedge clock) begin
      if (retire) begin
         hist_mem[wp_ff] <= smp;
      end
      if (rd_en) begin
         hist_q <= hist_mem[rd_ff];
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_samples_low  = out_ff[7:0];
   assign rsp_samples_high = out_ff[15:8];
   assign rsp_sample_count = ocnt_ff;
   assign rsp_last_group   = olast_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0 &&
                     rsp_sample_count <= COUNT_W'(SAMPLES_PER_RESULT)))
      else $error("result group count out of range");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count above history depth");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (gcnt_ff == '0))
      else $error("byte taken with a partial group pending");
   a_issue_last: assert property (@(posedge clock) disable iff (reset)
      (issue && rem_ff == LEN_W'(1)) |=> !busy_ff)
      else $error("generator busy after final sample");
`endif

endmodule
